### sv/chse_pkg.sv
// Shared types and constants for the cubic Hermite spline evaluator.
package chse_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 22;
  localparam int unsigned CFG_W = 7;
  localparam int unsigned TAN_W = 34;
  localparam int unsigned F_W   = 17;
  localparam int unsigned H_W   = 32;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_EVAL   = 1'b1;

  localparam logic [1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EVALUATED = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  // end tangent, 0.5 in Q16.16
  localparam logic signed [TAN_W-1:0] END_TANGENT = 34'sd32768;

  typedef struct packed {
    logic                    cmd;
    logic signed [VAL_W-1:0] node_value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [1:0]              status;
  } result_t;

  typedef struct packed {
    logic signed [H_W-1:0] h00;
    logic signed [H_W-1:0] h10;
    logic signed [H_W-1:0] h01;
    logic signed [H_W-1:0] h11;
  } basis_t;

endpackage

### sv/chse_basis.sv
// Hermite basis pipeline: t^2, t^3 and the four rounded Q2.30 basis weights.
module chse_basis (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [chse_pkg::F_W-1:0] f,
  output logic                     out_valid,
  output chse_pkg::basis_t         h
);
  import chse_pkg::*;

  logic           v1;
  logic           v2;
  logic [F_W-1:0] f1;
  logic [F_W-1:0] f2;
  logic [32:0]    t2;
  logic [32:0]    t2b;
  logic [48:0]    t3;

  logic signed [51:0] a;
  logic signed [51:0] b;
  logic signed [51:0] c;
  logic signed [51:0] one;
  basis_t             h_next;

  // round half up at bit 18, keep Q2.30
  function automatic logic signed [H_W-1:0] rnd(input logic signed [51:0] x);
    logic signed [51:0] y;
    y = (x + 52'sd131072) >>> 18;
    return y[H_W-1:0];
  endfunction

  // advance valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // square, then cube
  always_ff @(posedge clk) begin
    t2  <= 33'(f) * 33'(f);
    f1  <= f;
    t3  <= 49'(t2) * 49'(f1);
    t2b <= t2;
    f2  <= f1;
  end

  // combine powers into weights
  always_comb begin
    a   = signed'({3'b0, t3});
    b   = signed'({3'b0, t2b, 16'b0});
    c   = signed'({3'b0, f2, 32'b0});
    one = 52'sd1 <<< 48;
    h_next.h00 = rnd((a <<< 1) - (b <<< 1) - b + one);
    h_next.h10 = rnd(a - (b <<< 1) + c);
    h_next.h01 = rnd((b <<< 1) + b - (a <<< 1));
    h_next.h11 = rnd(a - b);
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      h <= h_next;
    end
  end

endmodule

### sv/cubic_hermite_spline_eval_unit.sv
// Top level of the cubic Hermite spline evaluator.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------
//  item in  | start, busy          | item   (in_item_t)
//  result   | done (strobe)        | result (result_t)
//  config   | cfg_valid, cfg_ready | cfg_data (node_count)
//
// An append does not raise busy; its result strobes the cycle after acceptance.
// An evaluation holds busy through the basis multiplies and the product stage;
// the sum is combinational, and its rounded, saturated value is registered as
// the result; busy is low again when it strobes. Inner tangents are written to
// the tangent memory as nodes arrive. Synchronous reset clears the load count
// and sets node_count to 4, or to MAX_NODES if smaller. A node_count write is
// taken only when idle with no item offered. The receiver cannot stall results.
module cubic_hermite_spline_eval_unit #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  chse_pkg::in_item_t         item,
  output logic                       done,
  output chse_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [chse_pkg::CFG_W-1:0] cfg_data
);
  import chse_pkg::*;

  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned VW = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned PW = (CW + 15 > POS_W) ? CW + 15 : POS_W;
  localparam int unsigned IW = PW - 15;
  localparam int unsigned SW = 68;
  localparam int unsigned RST_COUNT = (MAX_NODES < 4) ? MAX_NODES : 4;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BASIS = 2'd1;
  localparam logic [1:0] S_MUL   = 2'd2;

  localparam logic signed [SW-1:0] HALF = SW'(1) <<< 30;
  localparam logic signed [SW-1:0] SMAX = SW'(32'h7FFFFFFF);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  logic [1:0]    state;
  logic [CW-1:0] load_count;
  logic [CW-1:0] node_count;
  logic          full;
  logic          acc;
  logic          app_acc;
  logic          ev_acc;
  logic          cfg_acc;

  logic signed [VAL_W-1:0] node_mem [MAX_NODES];
  logic signed [TAN_W-1:0] tan_mem  [MAX_NODES];

  logic signed [VAL_W-1:0] prev1;
  logic signed [VAL_W-1:0] prev2;
  logic [AW-1:0]           lc_a;
  logic [AW-1:0]           tw_a;
  logic                    tan_we;
  logic signed [TAN_W-1:0] tan_val;

  logic [VW-1:0] cfg_wide;
  logic [CW-1:0] cfg_clamped;

  logic [PW-1:0]  top_pos;
  logic [PW-1:0]  pos_w;
  logic [PW-1:0]  pos_c;
  logic [IW-1:0]  idx_w;
  logic [IW-1:0]  nm1;
  logic [IW-1:0]  idx_c;
  logic [F_W-1:0] f_c;
  logic [AW-1:0]  idx_a;
  logic [AW-1:0]  idx1_a;
  logic           first;
  logic           last;

  logic signed [VAL_W-1:0] p0;
  logic signed [VAL_W-1:0] p1;
  logic signed [TAN_W-1:0] m0r;
  logic signed [TAN_W-1:0] m1r;
  logic signed [TAN_W-1:0] m0;
  logic signed [TAN_W-1:0] m1;
  logic                    first_r;
  logic                    last_r;

  logic   h_valid;
  basis_t h;

  logic signed [63:0] pr0;
  logic signed [65:0] pr1;
  logic signed [63:0] pr2;
  logic signed [65:0] pr3;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] rounded;
  logic signed [VAL_W-1:0] sat;

  // handshakes; hold off a config write while an item is offered
  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign acc       = start && !busy;
  assign app_acc   = acc && (item.cmd == CMD_APPEND);
  assign ev_acc    = acc && (item.cmd == CMD_EVAL) && full;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign full      = (load_count == node_count);

  // clamp the written node count to the supported range
  always_comb begin
    cfg_wide = VW'(cfg_data);
    if (cfg_wide < VW'(2)) begin
      cfg_clamped = CW'(2);
    end else if (cfg_wide > VW'(MAX_NODES)) begin
      cfg_clamped = CW'(MAX_NODES);
    end else begin
      cfg_clamped = cfg_wide[CW-1:0];
    end
  end

  // node count and load count
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CW'(RST_COUNT);
      load_count <= '0;
    end else if (cfg_acc) begin
      node_count <= cfg_clamped;
      load_count <= '0;
    end else if (app_acc && !full) begin
      load_count <= load_count + CW'(1);
    end
  end

  // inner tangent p[k] - p[k-2] lands at entry k-1 as node k arrives
  assign lc_a    = load_count[AW-1:0];
  assign tw_a    = lc_a - AW'(1);
  assign tan_we  = app_acc && !full && (load_count >= CW'(2));
  assign tan_val = TAN_W'(item.node_value) - TAN_W'(prev2);

  always_ff @(posedge clk) begin
    if (app_acc && !full) begin
      prev2 <= prev1;
      prev1 <= item.node_value;
    end
  end

  // clamp position, find interval and local t
  always_comb begin
    top_pos = PW'({node_count - CW'(1), 15'b0});
    pos_w   = PW'(item.position);
    pos_c   = (pos_w > top_pos) ? top_pos : pos_w;
    idx_w   = pos_c[PW-1:15];
    nm1     = IW'(node_count) - IW'(1);
    if (idx_w == nm1) begin
      idx_c = nm1 - IW'(1);
      f_c   = 17'h10000;
    end else begin
      idx_c = idx_w;
      f_c   = {1'b0, pos_c[14:0], 1'b0};
    end
    idx_a  = idx_c[AW-1:0];
    idx1_a = idx_a + AW'(1);
    first  = (idx_c == '0);
    last   = ((idx_c + IW'(1)) == nm1);
  end

  // node and tangent memories: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (app_acc && !full) begin
      node_mem[lc_a] <= item.node_value;
    end
    if (tan_we) begin
      tan_mem[tw_a] <= tan_val;
    end
    if (ev_acc) begin
      p0      <= node_mem[idx_a];
      p1      <= node_mem[idx1_a];
      m0r     <= tan_mem[idx_a];
      m1r     <= tan_mem[idx1_a];
      first_r <= first;
      last_r  <= last;
    end
  end

  // end tangents are fixed
  assign m0 = first_r ? END_TANGENT : m0r;
  assign m1 = last_r ? END_TANGENT : m1r;

  chse_basis u_basis (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ev_acc),
    .f         (f_c),
    .out_valid (h_valid),
    .h         (h)
  );

  // evaluation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (ev_acc) begin
            state <= S_BASIS;
          end
        end
        S_BASIS: begin
          if (h_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // weight the nodes and tangents
  always_ff @(posedge clk) begin
    if (state == S_BASIS && h_valid) begin
      pr0 <= h.h00 * p0;
      pr1 <= h.h10 * m0;
      pr2 <= h.h01 * p1;
      pr3 <= h.h11 * m1;
    end
  end

  // sum, round half up to Q16.16, saturate
  always_comb begin
    sum = (SW'(pr0) <<< 1) + SW'(pr1) + (SW'(pr2) <<< 1) + SW'(pr3);
    rounded = (sum + HALF) >>> 31;
    if (rounded > SMAX) begin
      sat = SMAX[VAL_W-1:0];
    end else if (rounded < SMIN) begin
      sat = SMIN[VAL_W-1:0];
    end else begin
      sat = rounded[VAL_W-1:0];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= app_acc || (acc && (item.cmd == CMD_EVAL) && !full) || (state == S_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (app_acc) begin
      result.value  <= '0;
      result.status <= full ? ST_FULL : ST_ACCEPTED;
    end else if (acc && !full) begin
      result.value  <= '0;
      result.status <= ST_NOT_READY;
    end else if (state == S_MUL) begin
      result.value  <= sat;
      result.status <= ST_EVALUATED;
    end
  end

  a_mul_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (done && result.status == ST_EVALUATED))
    else $error("evaluation result not delivered");

  a_eval_enters_seq: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_EVAL && full) |=> (state == S_BASIS && !done))
    else $error("evaluation did not start the sequencer");

  a_zero_unless_eval: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_EVALUATED) |-> (result.value == '0))
    else $error("non-evaluation result carries a value");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= node_count)
    else $error("load count passed node count");

endmodule
